[hw/rtl/mntp_pkg.sv]
// ----------------------------------------------------------------------------
// mntp_pkg: shared types and constants of the note token parser
// Parser state, result word layout and character decoding helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package mntp_pkg;

  localparam int DURATION_WIDTH = 16;
  localparam int CFG_WIDTH      = 16;
  localparam int BYTE_WIDTH     = 8;
  localparam int OUT_WIDTH      = 3 + 2 + DURATION_WIDTH + 1;
  localparam int OUT_TDATA_W    = ((OUT_WIDTH + 7) / 8) * 8;
  localparam int CMP_WIDTH      = (DURATION_WIDTH > CFG_WIDTH) ? DURATION_WIDTH : CFG_WIDTH;
  localparam int PADDR_WIDTH    = 3;

  localparam logic [DURATION_WIDTH-1:0] DUR_MAX = {DURATION_WIDTH{1'b1}};
  localparam logic [CFG_WIDTH-1:0] DEFAULT_DURATION_RESET = CFG_WIDTH'(4);

  localparam logic [BYTE_WIDTH-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_WIDTH-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_WIDTH-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_WIDTH-1:0] CH_NINE  = 8'h39;

  localparam logic [0:0] REG_DEFAULT_DURATION = 1'b0;

  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_PLUS  = 2'd1,
    ACC_MINUS = 2'd2
  } accidental_t;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_LETTER = 4'b0010,
    PH_ACC    = 4'b0100,
    PH_DIGITS = 4'b1000
  } phase_t;

  typedef struct packed {
    phase_t                    phase;
    logic [2:0]                letter;
    accidental_t               accidental;
    logic [DURATION_WIDTH-1:0] acc;
    logic                      overflow;
  } parse_state_t;

  typedef struct packed {
    logic                      sat;
    logic [DURATION_WIDTH-1:0] duration;
    accidental_t               accidental;
    logic [2:0]                letter;
  } note_t;

  typedef struct packed {
    logic  valid;
    note_t note;
  } note_result_t;

  function automatic logic [3:0] letter_code(input logic [BYTE_WIDTH-1:0] b);
    logic [3:0] code;
    code = 4'b0000;
    case (b)
      8'h63: code = 4'b1000;
      8'h64: code = 4'b1001;
      8'h65: code = 4'b1010;
      8'h66: code = 4'b1011;
      8'h67: code = 4'b1100;
      8'h61: code = 4'b1101;
      8'h62: code = 4'b1110;
      default: code = 4'b0000;
    endcase
    return code;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mntp_step.sv]
// ----------------------------------------------------------------------------
// mntp_step: one-byte parser step
// Next parser state and optional finished note for one text byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mntp_step (
  input  wire logic [mntp_pkg::BYTE_WIDTH-1:0] text_byte,
  input  wire logic [mntp_pkg::CFG_WIDTH-1:0]  default_duration,
  input  wire mntp_pkg::parse_state_t          cur,
  output mntp_pkg::parse_state_t               nxt,
  output mntp_pkg::note_result_t               result
);
  import mntp_pkg::*;

  logic                         is_digit;
  logic                         is_sign;
  logic [3:0]                   digit;
  logic [DURATION_WIDTH+3:0]    acc_x10;
  logic [3:0]                   code;
  logic [CMP_WIDTH-1:0]         dflt_ext;
  logic [DURATION_WIDTH-1:0]    dflt_clamped;
  logic                         check_letter;

  assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
  assign is_sign  = (text_byte == CH_PLUS) || (text_byte == CH_MINUS);
  assign digit    = 4'(text_byte - CH_ZERO);
  assign acc_x10  = ((DURATION_WIDTH+4)'(cur.acc) << 3) + ((DURATION_WIDTH+4)'(cur.acc) << 1)
                    + (DURATION_WIDTH+4)'(digit);
  assign code     = letter_code(text_byte);
  assign dflt_ext = CMP_WIDTH'(default_duration);

  always_comb begin
    if (dflt_ext > CMP_WIDTH'(DUR_MAX)) begin
      dflt_clamped = DUR_MAX;
    end else begin
      dflt_clamped = DURATION_WIDTH'(dflt_ext);
    end
  end

  always_comb begin
    nxt          = cur;
    result       = '0;
    check_letter = 1'b1;
    if (cur.phase != PH_IDLE) begin
      if ((cur.phase == PH_LETTER) && is_sign) begin
        nxt.accidental = (text_byte == CH_PLUS) ? ACC_PLUS : ACC_MINUS;
        nxt.phase      = PH_ACC;
        check_letter   = 1'b0;
      end else if (is_digit) begin
        check_letter = 1'b0;
        nxt.phase    = PH_DIGITS;
        if (cur.phase != PH_DIGITS) begin
          nxt.acc      = DURATION_WIDTH'(digit);
          nxt.overflow = 1'b0;
        end else if (!cur.overflow) begin
          if (acc_x10 > (DURATION_WIDTH+4)'(DUR_MAX)) begin
            nxt.acc      = DUR_MAX;
            nxt.overflow = 1'b1;
          end else begin
            nxt.acc = DURATION_WIDTH'(acc_x10);
          end
        end
      end else begin
        result.valid           = 1'b1;
        result.note.letter     = cur.letter;
        result.note.accidental = cur.accidental;
        if (cur.phase == PH_DIGITS) begin
          result.note.duration = cur.acc;
          result.note.sat      = cur.overflow;
        end else begin
          result.note.duration = dflt_clamped;
          result.note.sat      = 1'b0;
        end
        nxt.phase      = PH_IDLE;
        nxt.letter     = '0;
        nxt.accidental = ACC_NONE;
        nxt.acc        = '0;
        nxt.overflow   = 1'b0;
      end
    end
    if (check_letter && code[3]) begin
      nxt.letter     = code[2:0];
      nxt.accidental = ACC_NONE;
      nxt.acc        = '0;
      nxt.overflow   = 1'b0;
      nxt.phase      = PH_LETTER;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/music_note_token_parser.sv]
// ----------------------------------------------------------------------------
// music_note_token_parser: streaming note token scanner
// Scans text bytes for note letters, accidentals and durations.
// ----------------------------------------------------------------------------
// Input stream s_*: one text byte per word in s_tdata[7:0]; a zero byte ends
// the text and flushes a pending note. Output stream m_*: one finished note
// per word. A note leaves on the byte that cannot extend it. Throughput is
// one byte per cycle while s_tready is high: the parser state updates at each
// accepted byte through a single combinational step (multiply-by-ten
// accumulate and compare), and the note lands in an output register backed
// by a one-word skid register. s_tready drops only while the skid register
// holds a word, i.e. after the receiver has stalled with a note waiting and
// another note was produced; it returns the cycle after the receiver
// takes a word.
// Register 0 at byte address 0 (APB): default_duration, reset value 4.
// Reset (rst, synchronous) empties both output registers, clears the parser
// to idle with no note pending and restores the default duration.
// ----------------------------------------------------------------------------
`default_nettype none

module music_note_token_parser (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [7:0]                           s_tdata,   // [7:0] text_byte
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // [2:0] note_letter, [4:3] accidental, [20:5] duration, [21] duration_saturated
  output logic [mntp_pkg::OUT_TDATA_W-1:0]          m_tdata,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [mntp_pkg::PADDR_WIDTH-1:0]     paddr,
  input  wire logic [31:0]                          pwdata,
  output logic [31:0]                               prdata,
  output logic                                      pready
);
  import mntp_pkg::*;

  logic [CFG_WIDTH-1:0] default_duration;
  parse_state_t         state;
  parse_state_t         state_next;
  note_result_t         step_result;
  logic                 out_valid;
  note_t                out_data;
  logic                 skid_valid;
  note_t                skid_data;
  logic                 in_accept;
  logic                 out_take;
  logic                 push;
  logic                 reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_WIDTH-1] == REG_DEFAULT_DURATION);
  assign prdata  = reg_sel ? 32'(default_duration) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_duration <= DEFAULT_DURATION_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      default_duration <= pwdata[CFG_WIDTH-1:0];
    end
  end

  mntp_step u_step (
    .text_byte        (s_tdata),
    .default_duration (default_duration),
    .cur              (state),
    .nxt              (state_next),
    .result           (step_result)
  );

  assign s_tready  = !skid_valid;
  assign in_accept = s_tvalid && s_tready;
  assign m_tvalid  = out_valid;
  assign out_take  = out_valid && m_tready;
  assign push      = in_accept && step_result.valid;
  assign m_tdata   = OUT_TDATA_W'(out_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase: PH_IDLE, letter: '0, accidental: ACC_NONE, acc: '0, overflow: 1'b0};
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (push) begin
        out_data <= step_result.note;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid) begin
        skid_data  <= step_result.note;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= step_result.note;
        out_valid <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held with output register empty");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_tready))
    else $error("skid register filled without an output stall");

  a_sat_is_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.sat) |-> (out_data.duration == DUR_MAX))
    else $error("saturated note without maximum duration");

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_IDLE) |-> (state.acc == '0 && !state.overflow))
    else $error("idle parser holds accumulator state");
`endif

endmodule

`default_nettype wire

[tb/sv/tb_music_note_token_parser.sv]
// ----------------------------------------------------------------------------
// tb_music_note_token_parser: self-checking bench of the note token scanner
// Streams text bytes into the parser under random idling and output stalls,
// predicts every finished note with a local scanner and checks each output
// word field by field. The default duration register is written over APB
// between phases and read back.
// ----------------------------------------------------------------------------
module tb_music_note_token_parser;
  import mntp_pkg::*;

  localparam int STALL_MAX     = 11;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 240;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ROUND_BYTES   = 390;
  localparam int MAX_REPORTS   = 200;

  localparam logic [7:0] CH_END   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_HIGH  = 8'hFF;
  localparam logic [PADDR_WIDTH-1:0] DUR_ADDR = PADDR_WIDTH'(4 * REG_DEFAULT_DURATION);

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [7:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_WIDTH-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  logic [7:0] note_chars [0:6] = '{"c", "d", "e", "f", "g", "a", "b"};

  phase_t                    scan_phase;
  logic [2:0]                scan_letter;
  accidental_t               scan_accidental;
  logic [DURATION_WIDTH-1:0] scan_count;
  logic                      scan_overflow;
  logic [CFG_WIDTH-1:0]      dur_default;
  note_t                     notes_due [$];

  int  errors = 0;
  int  notes_checked = 0;
  int  notes_saturated = 0;
  int  bytes_sent = 0;
  int  token_bytes = 0;
  int  reg_writes = 0;
  int  cycles = 0;
  bit  tx_idle;
  bit  rx_idle;
  int  hold_request;

  music_note_token_parser dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    for (cycles = 0; cycles < CYCLE_LIMIT; cycles++) @(posedge clk);
    $display("timeout: %0d notes still outstanding", notes_due.size());
    $display("FAIL music_note_token_parser");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (errors < MAX_REPORTS) $display("mismatch: %s", what);
    errors++;
  endtask

  function automatic int note_index(input logic [7:0] b);
    int k;
    for (k = 0; k < 7; k++) if (b == note_chars[k]) return k;
    return -1;
  endfunction

  // advance the local scanner by one byte and queue the note it finishes
  function automatic void scan_byte(input logic [7:0] b);
    note_t n;
    logic [63:0] grown;
    int k;
    k = note_index(b);
    if (scan_phase != PH_IDLE) begin
      if (scan_phase == PH_LETTER && (b == CH_PLUS || b == CH_MINUS)) begin
        scan_accidental = (b == CH_PLUS) ? ACC_PLUS : ACC_MINUS;
        scan_phase = PH_ACC;
        return;
      end
      if (b >= CH_ZERO && b <= CH_NINE) begin
        if (scan_phase != PH_DIGITS) begin
          scan_count = DURATION_WIDTH'(b - CH_ZERO);
          scan_overflow = 1'b0;
          scan_phase = PH_DIGITS;
        end else if (!scan_overflow) begin
          grown = 64'(scan_count) * 10 + 64'(b - CH_ZERO);
          if (grown > 64'(DUR_MAX)) begin
            scan_count = DUR_MAX;
            scan_overflow = 1'b1;
          end else begin
            scan_count = DURATION_WIDTH'(grown);
          end
        end
        return;
      end
      n.letter = scan_letter;
      n.accidental = scan_accidental;
      if (scan_phase == PH_DIGITS) begin
        n.duration = scan_count;
        n.sat = scan_overflow;
      end else begin
        if (64'(dur_default) > 64'(DUR_MAX)) n.duration = DUR_MAX;
        else n.duration = DURATION_WIDTH'(dur_default);
        n.sat = 1'b0;
      end
      notes_due.push_back(n);
      scan_phase = PH_IDLE;
      scan_letter = '0;
      scan_accidental = ACC_NONE;
      scan_count = '0;
      scan_overflow = 1'b0;
    end
    if (k >= 0) begin
      scan_letter = 3'(k);
      scan_accidental = ACC_NONE;
      scan_count = '0;
      scan_overflow = 1'b0;
      scan_phase = PH_LETTER;
    end
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_idle ? $urandom_range(0, STALL_MAX) : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (s_tready !== 1'b1);
    scan_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // drop valid, wait for every queued note, then let the pipeline settle
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (notes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [PADDR_WIDTH-1:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    dur_default = value[CFG_WIDTH-1:0];
    reg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic read_reg(input logic [PADDR_WIDTH-1:0] addr, input logic [31:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want) report_mismatch($sformatf("prdata %h, expected %h", prdata, want));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_default(input logic [31:0] value);
    write_reg(DUR_ADDR, value);
    read_reg(DUR_ADDR, 32'(value[CFG_WIDTH-1:0]));
  endtask

  // one note token with random content, then a random way of ending it
  task automatic send_token();
    int pick;
    int ndig;
    int i;
    send_byte(note_chars[$urandom_range(0, 6)]);
    token_bytes++;
    pick = $urandom_range(0, 9);
    if (pick < 3) begin
      send_byte(CH_PLUS);
      token_bytes++;
    end else if (pick < 5) begin
      send_byte(CH_MINUS);
      token_bytes++;
    end
    pick = $urandom_range(0, 15);
    if (pick < 4) begin
      ndig = 0;
    end else if (pick < 13) begin
      ndig = $urandom_range(1, 4);
    end else if (pick < 15) begin
      ndig = $urandom_range(5, 9);
    end else begin
      send_text("6553");
      token_bytes += 4;
      ndig = 1;
    end
    for (i = 0; i < ndig; i++) begin
      send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
      token_bytes++;
    end
    pick = $urandom_range(0, 19);
    if (pick >= 8) begin
      if (pick < 10) send_byte(CH_END);
      else if (pick < 13) send_byte(CH_SPACE);
      else if (pick < 16) send_byte(8'($urandom_range(0, 255)));
      else if (pick < 18) send_byte(pick[0] ? CH_PLUS : CH_MINUS);
      else send_byte(8'($urandom_range(CH_UPPER_A, CH_UPPER_Z)));
    end
  endtask

  task automatic test_directed();
    send_text("cdefgab+65535e-99999");
    send_byte(CH_END);
    send_byte(CH_END);
    send_text("C5+a007");
    send_byte(CH_HIGH);
    send_text("f+-");
    drain();
  endtask

  task automatic test_default_duration();
    logic [31:0] values [0:3];
    int i;
    values[0] = 32'd0;
    values[1] = 32'd65535;
    values[2] = {16'($urandom), 16'($urandom_range(0, 65535))};
    values[3] = 32'd4;
    read_reg(DUR_ADDR, 32'(DEFAULT_DURATION_RESET));
    for (i = 0; i < 4; i++) begin
      set_default(values[i]);
      send_text("ab+c-");
      send_byte(CH_END);
      send_text("d12");
      send_byte(CH_END);
      drain();
    end
  endtask

  task automatic test_back_pressure();
    int i;
    tx_idle = 1'b0;
    hold_request = HOLD_CYCLES;
    for (i = 0; i < 24; i++) send_byte(note_chars[$urandom_range(0, 6)]);
    send_byte(CH_END);
    drain();
    tx_idle = 1'b1;
  endtask

  task automatic test_random_text();
    int round;
    int target;
    for (round = 0; round < 3; round++) begin
      case (round)
        0: set_default(32'($urandom_range(0, 65535)));
        1: set_default(32'($urandom_range(1, 16)));
        default: set_default({16'($urandom), 16'($urandom_range(0, 65535))});
      endcase
      target = token_bytes + ROUND_BYTES;
      while (token_bytes < target) begin
        if ($urandom_range(0, 39) == 0) begin
          tx_idle = ($urandom_range(0, 3) != 0);
          rx_idle = ($urandom_range(0, 3) != 0);
        end
        if ($urandom_range(0, 15) == 0) send_byte(8'($urandom_range(0, 255)));
        send_token();
      end
      send_byte(CH_END);
      drain();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    int w;
    m_tready = 1'b0;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        m_tready <= 1'b0;
        repeat (hold_request) @(negedge clk);
        hold_request = 0;
      end
      w = rx_idle ? $urandom_range(0, STALL_MAX) : 0;
      if (w > 0) begin
        m_tready <= 1'b0;
        repeat (w) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  always @(posedge clk) begin : note_check
    note_t got;
    note_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = note_t'(m_tdata[OUT_WIDTH-1:0]);
      if (notes_due.size() == 0) begin
        report_mismatch($sformatf("note word %h with none expected", m_tdata));
      end else begin
        want = notes_due.pop_front();
        notes_checked++;
        if (want.sat) notes_saturated++;
        if (got.letter !== want.letter)
          report_mismatch($sformatf("note %0d letter %0d, expected %0d",
                                    notes_checked, got.letter, want.letter));
        if (got.accidental !== want.accidental)
          report_mismatch($sformatf("note %0d accidental %0d, expected %0d",
                                    notes_checked, got.accidental, want.accidental));
        if (got.duration !== want.duration)
          report_mismatch($sformatf("note %0d duration %0d, expected %0d",
                                    notes_checked, got.duration, want.duration));
        if (got.sat !== want.sat)
          report_mismatch($sformatf("note %0d saturated %0d, expected %0d",
                                    notes_checked, got.sat, want.sat));
      end
    end
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    tx_idle  = 1'b1;
    rx_idle  = 1'b1;
    hold_request = 0;
    scan_phase = PH_IDLE;
    scan_letter = '0;
    scan_accidental = ACC_NONE;
    scan_count = '0;
    scan_overflow = 1'b0;
    dur_default = DEFAULT_DURATION_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_default_duration();
    test_back_pressure();
    test_random_text();

    $display("sent %0d text bytes (%0d in note tokens); checked %0d notes, %0d saturated",
             bytes_sent, token_bytes, notes_checked, notes_saturated);
    $display("default duration written %0d times incl. 0 and 65535; %0d-cycle output stall",
             reg_writes, HOLD_CYCLES);
    if (errors == 0) begin
      $display("PASS music_note_token_parser");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAIL music_note_token_parser");
    end
    $finish;
  end

endmodule

[music_note_token_parser.f]
hw/rtl/mntp_pkg.sv
hw/rtl/mntp_step.sv
hw/rtl/music_note_token_parser.sv
tb/sv/tb_music_note_token_parser.sv
